// ===== design/parent_sorted_key_table_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PARENT_SORTED_KEY_TABLE_ASSERT_SVH
`define PARENT_SORTED_KEY_TABLE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PSKT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PSKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pskt_pkg.sv =====
package pskt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_LIST   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EXISTS   = 3'd1;
    localparam logic [2:0] ST_NOPARENT = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] pkey;
        logic [31:0] data;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_key;
        logic [31:0] out_parent;
        logic [31:0] out_data;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] parent;
        logic [31:0] data;
    } entry_t;

endpackage

// ===== design/pskt_if.sv =====
interface pskt_req_if;
    import pskt_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pskt_rsp_if;
    import pskt_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/parent_sorted_key_table.sv =====
// One item at a time: the next input transfer is taken the cycle after the final result
// transfer. Every pass over the table handles one entry a cycle, except that a list pass
// waits while an earlier match is held for its transfer.
// Reset: asynchronous, active low; clears the entry count, the root key register and
// the sequencer. Entry storage is not cleared; only entries below the count are read.
module parent_sorted_key_table (
    input  logic                clk,
    input  logic                rst_n,
    pskt_req_if.sink            req,
    pskt_rsp_if.source          rsp,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata
);
    import pskt_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FINDK  = 4'd1;  // scan for the request key
    localparam logic [3:0] S_FINDP  = 4'd2;  // scan for the parent key (add)
    localparam logic [3:0] S_FINDPOS= 4'd3;  // scan for the insert position
    localparam logic [3:0] S_SHIFTU = 4'd4;  // shift entries up by one
    localparam logic [3:0] S_SHIFTD = 4'd5;  // shift entries down by one
    localparam logic [3:0] S_GATHER = 4'd6;  // reorder entries into scratch
    localparam logic [3:0] S_COPY   = 4'd7;  // copy scratch back
    localparam logic [3:0] S_LIST   = 4'd8;  // scan and collect matches
    localparam logic [3:0] S_OUT    = 4'd9;  // final result waits for transfer
    localparam logic [3:0] S_LWAIT  = 4'd10; // earlier list match waits for transfer

    // Main table and scratch table; both written and read in clocked blocks.
    entry_t mem [CAPACITY];
    entry_t tmp [CAPACITY];
    entry_t rd_reg;          // registered read of mem
    entry_t trd_reg;         // registered read of tmp

    logic [3:0]       state_reg, state_next;
    logic [31:0]      base_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    req_t             req_reg;
    rsp_t             rsp_reg, rsp_next;

    // Scan pointer: the address presented last cycle, whose data is in rd_reg.
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             rdv_reg, rdv_next;      // rd_reg holds entry ptr_reg
    logic [CNT_W-1:0] pos_reg, pos_next;      // found position
    logic             found_reg, found_next;
    logic [1:0]       pass_reg, pass_next;    // gather pass
    logic [CNT_W-1:0] n_reg, n_next;          // gather fill
    logic             any_reg, any_next;      // list holds a pending match

    // Memory control.
    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    entry_t           wdata;
    logic             twe;
    logic [IDX_W-1:0] twaddr, traddr;
    entry_t           twdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
        if (twe)
        begin
            tmp[twaddr] <= twdata;
        end
        trd_reg <= tmp[traddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg  <= '0;
            count_reg <= '0;
            ptr_reg   <= '0;
            rdv_reg   <= 1'b0;
            pos_reg   <= '0;
            found_reg <= 1'b0;
            pass_reg  <= '0;
            n_reg     <= '0;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            rdv_reg   <= rdv_next;
            pos_reg   <= pos_next;
            found_reg <= found_next;
            pass_reg  <= pass_next;
            n_reg     <= n_next;
            any_reg   <= any_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= req.payload;
        end
        rsp_reg <= rsp_next;
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = (state_reg == S_OUT) || (state_reg == S_LWAIT);
    assign rsp.payload = rsp_reg;

    // Key compare shared by both key scans: the entry just read against a chosen key.
    logic [31:0] cmp_key;
    logic        cmp_eq;
    logic [1:0]  cls;
    assign cmp_eq = (rd_reg.key == cmp_key);
    assign cls = (rd_reg.parent == 32'd0) ? 2'd0 :
                 ((rd_reg.parent == req_reg.key) ? 2'd1 : 2'd2);

    logic [IDX_W-1:0] ptr_idx;
    assign ptr_idx = ptr_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        rdv_next   = 1'b0;
        pos_next   = pos_reg;
        found_next = found_reg;
        pass_next  = pass_reg;
        n_next     = n_reg;
        any_next   = any_reg;
        rsp_next   = rsp_reg;
        we = 1'b0; waddr = ptr_idx; wdata = rd_reg; raddr = '0;
        twe = 1'b0; twaddr = n_reg[IDX_W-1:0]; twdata = rd_reg; traddr = '0;
        cmp_key = req_reg.key;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    ptr_next   = '0;
                    found_next = 1'b0;
                    any_next   = 1'b0;
                    raddr      = '0;
                    rdv_next   = 1'b1;
                    state_next = (req.payload.cmd == CMD_LIST) ? S_LIST : S_FINDK;
                end
            end

            S_FINDK, S_FINDP:
            begin
                if (state_reg == S_FINDP)
                begin
                    cmp_key = req_reg.pkey;
                end
                if (ptr_reg < count_reg && rdv_reg && cmp_eq)
                begin
                    found_next = 1'b1;
                    pos_next   = ptr_reg;
                end
                if (ptr_reg < count_reg && !(rdv_reg && cmp_eq))
                begin
                    ptr_next = ptr_reg + 1'b1;
                    raddr    = ptr_next[IDX_W-1:0];
                    rdv_next = 1'b1;
                end
                else
                begin
                    // Scan done; found_next says whether the key exists.
                    rsp_next.out_key    = req_reg.key;
                    rsp_next.out_parent = 32'd0;
                    rsp_next.out_data   = 32'd0;
                    rsp_next.last       = 1'b1;
                    ptr_next = '0;
                    raddr    = '0;
                    rdv_next = 1'b1;
                    if (state_reg == S_FINDP)
                    begin
                        rsp_next.out_parent = req_reg.pkey;
                        if (!found_next)
                        begin
                            rsp_next.status = ST_NOPARENT;
                            state_next = S_OUT;
                        end
                        else if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            rsp_next.status = ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_FINDPOS;
                        end
                    end
                    else
                    begin
                        case (req_reg.cmd)
                            CMD_ADD:
                            begin
                                rsp_next.out_parent = req_reg.pkey;
                                if (found_next)
                                begin
                                    rsp_next.status = ST_EXISTS;
                                    state_next = S_OUT;
                                end
                                else if (req_reg.pkey == 32'd0 ||
                                         req_reg.pkey == base_reg)
                                begin
                                    if (count_reg >= CNT_W'(CAPACITY))
                                    begin
                                        rsp_next.status = ST_FULL;
                                        state_next = S_OUT;
                                    end
                                    else
                                    begin
                                        state_next = S_FINDPOS;
                                    end
                                end
                                else
                                begin
                                    found_next = 1'b0;
                                    state_next = S_FINDP;
                                end
                            end
                            CMD_LOOKUP:
                            begin
                                if (found_next)
                                begin
                                    rsp_next.status     = ST_OK;
                                    rsp_next.out_parent = rd_reg.parent;
                                    rsp_next.out_data   = rd_reg.data;
                                end
                                else
                                begin
                                    rsp_next.status = ST_NOTFOUND;
                                end
                                state_next = S_OUT;
                            end
                            default:
                            begin
                                // Delete.
                                rsp_next.status = ST_OK;
                                if (!found_next && req_reg.key != base_reg)
                                begin
                                    rsp_next.status = ST_NOTFOUND;
                                    state_next = S_OUT;
                                end
                                else if (found_next)
                                begin
                                    ptr_next = pos_next;
                                    raddr    = pos_next[IDX_W-1:0] + 1'b1;
                                    state_next = S_SHIFTD;
                                end
                                else if (req_reg.key == 32'd0)
                                begin
                                    state_next = S_OUT;
                                end
                                else
                                begin
                                    pass_next  = '0;
                                    n_next     = '0;
                                    state_next = S_GATHER;
                                end
                            end
                        endcase
                    end
                end
            end

            S_FINDPOS:
            begin
                // First entry whose parent exceeds the new parent key.
                if (ptr_reg < count_reg && rd_reg.parent <= req_reg.pkey)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    raddr    = ptr_next[IDX_W-1:0];
                    rdv_next = 1'b1;
                end
                else
                begin
                    pos_next = ptr_reg;
                    ptr_next = count_reg;
                    raddr    = count_reg[IDX_W-1:0] - 1'b1;
                    state_next = S_SHIFTU;
                end
            end

            S_SHIFTU:
            begin
                // rd_reg holds entry ptr_reg-1; write it to ptr_reg.
                if (ptr_reg > pos_reg)
                begin
                    we       = 1'b1;
                    ptr_next = ptr_reg - 1'b1;
                    raddr    = ptr_next[IDX_W-1:0] - 1'b1;
                end
                else
                begin
                    we = 1'b1;
                    wdata.key    = req_reg.key;
                    wdata.parent = req_reg.pkey;
                    wdata.data   = req_reg.data;
                    count_next   = count_reg + 1'b1;
                    rsp_next.status = ST_OK;
                    state_next = S_OUT;
                end
            end

            S_SHIFTD:
            begin
                // rd_reg holds entry ptr_reg+1; write it to ptr_reg.
                if (ptr_reg + 1'b1 < count_reg)
                begin
                    we       = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                    raddr    = ptr_next[IDX_W-1:0] + 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (req_reg.key == 32'd0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ptr_next  = '0;
                        raddr     = '0;
                        rdv_next  = 1'b1;
                        pass_next = '0;
                        n_next    = '0;
                        state_next = S_GATHER;
                    end
                end
            end

            S_GATHER:
            begin
                // Three passes: zero parents, children of the key, the rest.
                if (ptr_reg < count_reg)
                begin
                    if (cls == pass_reg)
                    begin
                        twe = 1'b1;
                        if (cls == 2'd1)
                        begin
                            twdata.parent = 32'd0;
                        end
                        n_next = n_reg + 1'b1;
                    end
                    ptr_next = ptr_reg + 1'b1;
                    raddr    = ptr_next[IDX_W-1:0];
                end
                else if (pass_reg != 2'd2)
                begin
                    pass_next = pass_reg + 1'b1;
                    ptr_next  = '0;
                    raddr     = '0;
                end
                else
                begin
                    ptr_next = '0;
                    traddr   = '0;
                    state_next = S_COPY;
                end
            end

            S_COPY:
            begin
                if (ptr_reg < n_reg)
                begin
                    we       = 1'b1;
                    wdata    = trd_reg;
                    ptr_next = ptr_reg + 1'b1;
                    traddr   = ptr_next[IDX_W-1:0];
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_LIST:
            begin
                // A match is held in rsp_reg until the scan reaches the next
                // match or the end, so that last is known before it is shown.
                if (ptr_reg < count_reg)
                begin
                    if (rd_reg.parent == req_reg.pkey && any_reg)
                    begin
                        // Show the pending match; this entry is examined again
                        // once that transfer is done.
                        raddr      = ptr_idx;
                        state_next = S_LWAIT;
                    end
                    else
                    begin
                        if (rd_reg.parent == req_reg.pkey)
                        begin
                            any_next = 1'b1;
                            rsp_next.status     = ST_OK;
                            rsp_next.out_key    = rd_reg.key;
                            rsp_next.out_parent = rd_reg.parent;
                            rsp_next.out_data   = rd_reg.data;
                            rsp_next.last       = 1'b0;
                        end
                        ptr_next = ptr_reg + 1'b1;
                        raddr    = ptr_next[IDX_W-1:0];
                    end
                end
                else
                begin
                    if (!any_reg)
                    begin
                        rsp_next.status     = ST_NOTFOUND;
                        rsp_next.out_key    = req_reg.key;
                        rsp_next.out_parent = req_reg.pkey;
                        rsp_next.out_data   = 32'd0;
                    end
                    rsp_next.last = 1'b1;
                    state_next = S_OUT;
                end
            end

            S_LWAIT:
            begin
                // Keep the current entry in rd_reg while the result waits.
                raddr = ptr_idx;
                if (rsp.ready)
                begin
                    any_next   = 1'b0;
                    state_next = S_LIST;
                end
            end

            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/pskt_checker.sv =====
module pskt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  rsp_status,
    input logic        rsp_last
);
    import pskt_pkg::*;
`include "parent_sorted_key_table_assert.svh"

    `PSKT_ASSERT_IMPL(a_no_overlap, clk, rst_n, rsp_valid, !req_ready, "input taken while a result is shown")
    `PSKT_ASSERT_IMPL(a_status_range, clk, rst_n, rsp_valid, rsp_status <= ST_NOTFOUND, "status code out of range")
    `PSKT_ASSERT_IMPL(a_error_is_last, clk, rst_n, rsp_valid && rsp_status != ST_OK, rsp_last, "error status on a result that is not the last")
    `PSKT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "result withdrawn before transfer")
    `PSKT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready, "ready again right after a transfer")

endmodule

bind parent_sorted_key_table pskt_checker u_pskt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.payload.status),
    .rsp_last   (rsp.payload.last)
);
